### src/gmrm_pkg.sv
// Shared types and constants for the greedy mask rectangle merger.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gmrm_pkg;
  localparam int MASK_DIM   = 16;
  localparam int LAYER_BITS = 16;
  localparam int COORD_BITS = $clog2(MASK_DIM);
  localparam int DIM_BITS   = COORD_BITS + 1;
  localparam int CELL_COUNT = MASK_DIM * MASK_DIM;
  localparam int ADDR_BITS  = 2 * COORD_BITS;
  localparam int CELL_BITS  = 1 + LAYER_BITS + 8;
  localparam int FIELD_COORD = 4;
  localparam int FIELD_DIM   = 5;
  localparam int FIELD_LAYER = 16;
  localparam int CFG_BITS    = 5;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic                  filled;
    logic [LAYER_BITS-1:0] layer;
    logic [1:0]            ao0;
    logic [1:0]            ao1;
    logic [1:0]            ao2;
    logic [1:0]            ao3;
  } cell_t;

  // controller -> datapath
  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_START, OP_SCAN_RD, OP_SCAN_CHK, OP_BASE, OP_RD, OP_RCHK,
    OP_DCHK, OP_MARK_INIT, OP_MARK, OP_DONE_FOUND, OP_DONE_EMPTY
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;   // scan position past last row
    logic hit;        // last read cell filled and unconsumed
    logic match;      // last read cell mergeable
    logic row_end;    // grow-right cursor at width limit
    logic seg_end;    // segment column cursor at last column of rect
    logic down_end;   // no further row to test
    logic mark_end;   // last cell marked
  } status_t;
endpackage
`default_nettype wire

### src/gmrm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gmrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### src/gmrm_datapath.sv
// Datapath: cell store RAM holding each cell with its consumed mark, scan and grow
// cursors, result register. Depends on gmrm_pkg and gmrm_ram.
`timescale 1ns / 1ps
`default_nettype none
module gmrm_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire gmrm_pkg::cmd_t                     cmd,
  output gmrm_pkg::status_t                       status,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_idx,
  input  wire logic [gmrm_pkg::CFG_BITS-1:0]      cfg_data,
  input  wire logic [gmrm_pkg::FIELD_COORD-1:0]   in_col,
  input  wire logic [gmrm_pkg::FIELD_COORD-1:0]   in_row,
  input  wire gmrm_pkg::cell_t                    in_cell,
  output logic                                    o_valid,
  output logic [gmrm_pkg::FIELD_COORD-1:0]        o_col,
  output logic [gmrm_pkg::FIELD_COORD-1:0]        o_row,
  output logic [gmrm_pkg::FIELD_DIM-1:0]          o_width,
  output logic [gmrm_pkg::FIELD_DIM-1:0]          o_height,
  output gmrm_pkg::cell_t                         o_cell
);
  import gmrm_pkg::*;

  logic [CFG_BITS-1:0] mask_width, mask_height;
  logic [DIM_BITS-1:0] w, h;
  logic [DIM_BITS-1:0] scan_col, scan_row;    // may reach w / h
  logic [DIM_BITS-1:0] rw, rh, du, dv;
  cell_t base;
  logic [DIM_BITS-1:0] rd_col, rd_row;
  logic [ADDR_BITS-1:0] rd_addr, ram_addr;
  logic ram_we;
  logic [CELL_BITS:0] ram_wdata, ram_rdata;
  cell_t rdata;
  logic rd_cons;

  function automatic logic [DIM_BITS-1:0] clamp(input logic [CFG_BITS-1:0] v);
    if (v == '0) return DIM_BITS'(1);
    if (32'(v) > MASK_DIM) return DIM_BITS'(MASK_DIM);
    return DIM_BITS'(v);
  endfunction

  assign w = clamp(mask_width);
  assign h = clamp(mask_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width  <= CFG_BITS'(16);
      mask_height <= CFG_BITS'(16);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_WIDTH) mask_width <= cfg_data;
      else mask_height <= cfg_data;
    end
  end

  // read and mark address chosen by operation
  always_comb begin
    rd_col = scan_col;
    rd_row = scan_row;
    unique case (cmd.op)
      OP_RD, OP_MARK: begin
        rd_col = scan_col + du;
        rd_row = scan_row + dv;
      end
      default: ;
    endcase
  end
  assign rd_addr = {rd_row[COORD_BITS-1:0], rd_col[COORD_BITS-1:0]};
  assign ram_we = (cmd.op == OP_WRITE) || (cmd.op == OP_MARK);
  assign ram_addr = (cmd.op == OP_WRITE) ? {in_row[COORD_BITS-1:0], in_col[COORD_BITS-1:0]}
                                         : rd_addr;
  // marked cells all equal the base cell, so rewrite it with the mark set
  assign ram_wdata = (cmd.op == OP_MARK) ? {1'b1, base} : {1'b0, in_cell};

  gmrm_ram #(.WIDTH(CELL_BITS + 1), .DEPTH(CELL_COUNT)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign rd_cons = ram_rdata[CELL_BITS];
  assign rdata   = cell_t'(ram_rdata[CELL_BITS-1:0]);

  assign status.scan_end = (scan_row >= h);
  assign status.hit      = rdata.filled && !rd_cons;
  assign status.match    = rdata.filled && !rd_cons && (rdata.layer == base.layer) &&
                           rdata.ao0 == base.ao0 && rdata.ao1 == base.ao1 &&
                           rdata.ao2 == base.ao2 && rdata.ao3 == base.ao3;
  assign status.row_end  = (scan_col + rw >= w);
  assign status.seg_end  = (du + DIM_BITS'(1) >= rw);
  assign status.down_end = (scan_row + rh >= h);
  assign status.mark_end = (du + DIM_BITS'(1) >= rw) && (dv + DIM_BITS'(1) >= rh);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_row <= '0;
      o_valid  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_WRITE: begin
          scan_col <= '0;
          scan_row <= '0;
        end
        OP_START: begin
          // step off an out-of-range column before reading
          if (scan_col >= w) begin
            scan_col <= '0;
            scan_row <= scan_row + DIM_BITS'(1);
          end
        end
        OP_SCAN_CHK: begin
          if (!status.hit) begin
            if (scan_col + DIM_BITS'(1) >= w) begin
              scan_col <= '0;
              scan_row <= scan_row + DIM_BITS'(1);
            end else begin
              scan_col <= scan_col + DIM_BITS'(1);
            end
          end
        end
        OP_BASE: begin
          base <= rdata;
          rw <= DIM_BITS'(1);
          rh <= DIM_BITS'(1);
          du <= DIM_BITS'(1);
          dv <= '0;
        end
        OP_RCHK: begin
          // matched: grow right, or advance along the row segment below
          if (dv == '0) begin
            rw <= rw + DIM_BITS'(1);
            du <= du + DIM_BITS'(1);
          end else if (status.seg_end) begin
            rh <= rh + DIM_BITS'(1);
            du <= '0;
            dv <= dv + DIM_BITS'(1);
          end else begin
            du <= du + DIM_BITS'(1);
          end
        end
        OP_DCHK: begin
          // switch to the first row below the rectangle
          du <= '0;
          dv <= rh;
        end
        OP_MARK_INIT: begin
          du <= '0;
          dv <= '0;
        end
        OP_MARK: begin
          if (status.seg_end) begin
            du <= '0;
            dv <= dv + DIM_BITS'(1);
          end else begin
            du <= du + DIM_BITS'(1);
          end
        end
        OP_DONE_FOUND: begin
          o_valid  <= 1'b1;
          o_col    <= FIELD_COORD'(scan_col);
          o_row    <= FIELD_COORD'(scan_row);
          o_width  <= FIELD_DIM'(rw);
          o_height <= FIELD_DIM'(rh);
          o_cell   <= base;
        end
        OP_DONE_EMPTY: begin
          scan_row <= h;
          scan_col <= '0;
          o_valid  <= 1'b0;
          o_col    <= '0;
          o_row    <= '0;
          o_width  <= '0;
          o_height <= '0;
          o_cell   <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/gmrm_ctrl.sv
// Controller state machine sequencing scan, grow and mark steps.
// Depends on gmrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmrm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gmrm_pkg::status_t status,
  output gmrm_pkg::cmd_t         cmd
);
  import gmrm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_START = 10'b0000000010,
    S_SRD   = 10'b0000000100,
    S_SCHK  = 10'b0000001000,
    S_BASE  = 10'b0000010000,
    S_RD    = 10'b0000100000,
    S_CHK   = 10'b0001000000,
    S_MARK  = 10'b0010000000,
    S_FOUND = 10'b0100000000,
    S_EMPTY = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic out_full;
  logic grow_down;   // set once right-growth has ended
  logic done;

  // item may enter once the result register is free to be reloaded
  assign in_ready = (state == S_IDLE) && !(out_full && !out_ready);
  assign out_valid = out_full;
  assign done = (state == S_FOUND) || (state == S_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (done) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) grow_down <= 1'b0;
    else if (state == S_BASE) grow_down <= 1'b0;
    else if (cmd.op == OP_DCHK) grow_down <= 1'b1;
  end

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_mode == MODE_WRITE) cmd.op = OP_WRITE;
          else state_next = S_START;
        end
      end
      S_START: begin
        cmd.op = OP_START;
        state_next = S_SRD;
      end
      S_SRD: begin
        if (status.scan_end) state_next = S_EMPTY;
        else begin
          cmd.op = OP_SCAN_RD;
          state_next = S_SCHK;
        end
      end
      S_SCHK: begin
        cmd.op = OP_SCAN_CHK;
        state_next = status.hit ? S_BASE : S_SRD;
      end
      S_BASE: begin
        cmd.op = OP_BASE;
        state_next = S_RD;
      end
      S_RD: begin
        // test the bound before each read
        if (!grow_down) begin
          if (status.row_end) cmd.op = OP_DCHK;
          else begin
            cmd.op = OP_RD;
            state_next = S_CHK;
          end
        end else begin
          if (status.down_end) begin
            cmd.op = OP_MARK_INIT;
            state_next = S_MARK;
          end else begin
            cmd.op = OP_RD;
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (status.match) begin
          cmd.op = OP_RCHK;
          state_next = S_RD;
        end else if (!grow_down) begin
          cmd.op = OP_DCHK;
          state_next = S_RD;
        end else begin
          cmd.op = OP_MARK_INIT;
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (status.mark_end) state_next = S_FOUND;
      end
      S_FOUND: begin
        cmd.op = OP_DONE_FOUND;
        state_next = S_IDLE;
      end
      S_EMPTY: begin
        cmd.op = OP_DONE_EMPTY;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

### src/greedy_mask_rectangle_merger.sv
// Top level of the greedy mask rectangle merger: controller plus datapath.
// Depends on gmrm_pkg, gmrm_ctrl, gmrm_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mode, cell_*
//   out      output     out_valid / out_ready  rect_*
//   cfg      input      cfg_we                 cfg_idx, cfg_data
//
// A write item is stored in the idle state. A fetch takes a start step, a read
// and a check per scanned cell, a base step, a read and a check per compared cell
// while growing, an extra step where growth hits the width and where it hits the
// height, a step per marked cell and one to load the result; the single-port cell
// RAM sets that pace. The result register holds an item until taken; a new item
// enters once it is free or being taken. Consumed marks sit beside each cell in
// the RAM and clear when the cell is written, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module greedy_mask_rectangle_merger (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  mode,
  input  wire logic [gmrm_pkg::FIELD_COORD-1:0]      cell_col,
  input  wire logic [gmrm_pkg::FIELD_COORD-1:0]      cell_row,
  input  wire logic                                  cell_filled,
  input  wire logic [gmrm_pkg::FIELD_LAYER-1:0]      cell_layer,
  input  wire logic [1:0]                            cell_ao0,
  input  wire logic [1:0]                            cell_ao1,
  input  wire logic [1:0]                            cell_ao2,
  input  wire logic [1:0]                            cell_ao3,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       rect_valid,
  output logic [gmrm_pkg::FIELD_COORD-1:0]           rect_col,
  output logic [gmrm_pkg::FIELD_COORD-1:0]           rect_row,
  output logic [gmrm_pkg::FIELD_DIM-1:0]             rect_width,
  output logic [gmrm_pkg::FIELD_DIM-1:0]             rect_height,
  output logic [gmrm_pkg::FIELD_LAYER-1:0]           rect_layer,
  output logic [1:0]                                 rect_ao0,
  output logic [1:0]                                 rect_ao1,
  output logic [1:0]                                 rect_ao2,
  output logic [1:0]                                 rect_ao3,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_idx,
  input  wire logic [gmrm_pkg::CFG_BITS-1:0]         cfg_data
);
  import gmrm_pkg::*;

  cmd_t cmd;
  status_t status;
  cell_t in_cell, o_cell;

  assign in_cell = '{filled: cell_filled, layer: LAYER_BITS'(cell_layer),
                     ao0: cell_ao0, ao1: cell_ao1, ao2: cell_ao2, ao3: cell_ao3};

  gmrm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_mode(mode),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  gmrm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_col(cell_col), .in_row(cell_row), .in_cell(in_cell),
    .o_valid(rect_valid), .o_col(rect_col), .o_row(rect_row),
    .o_width(rect_width), .o_height(rect_height), .o_cell(o_cell)
  );

  assign rect_layer = FIELD_LAYER'(o_cell.layer);
  assign rect_ao0 = o_cell.ao0;
  assign rect_ao1 = o_cell.ao1;
  assign rect_ao2 = o_cell.ao2;
  assign rect_ao3 = o_cell.ao3;
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for greedy_mask_rectangle_merger: cell loads and rectangle fetches
// against an in-bench merge predictor. Depends on gmrm_pkg and the merger RTL.
`timescale 1ns / 1ps
module tb;
  import gmrm_pkg::*;

  typedef struct {
    logic        mode;
    logic [3:0]  col;
    logic [3:0]  row;
    logic        filled;
    logic [15:0] layer;
    logic [1:0]  ao0, ao1, ao2, ao3;
  } mask_item_t;

  typedef struct {
    logic        valid;
    logic [3:0]  col;
    logic [3:0]  row;
    logic [4:0]  width;
    logic [4:0]  height;
    logic [15:0] layer;
    logic [1:0]  ao0, ao1, ao2, ao3;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [3:0] cell_col = '0, cell_row = '0;
  logic cell_filled = 1'b0;
  logic [15:0] cell_layer = '0;
  logic [1:0] cell_ao0 = '0, cell_ao1 = '0, cell_ao2 = '0, cell_ao3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic rect_valid;
  logic [3:0] rect_col, rect_row;
  logic [4:0] rect_width, rect_height;
  logic [15:0] rect_layer;
  logic [1:0] rect_ao0, rect_ao1, rect_ao2, rect_ao3;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_WIDTH;
  logic [4:0] cfg_data = '0;

  greedy_mask_rectangle_merger dut (.*);

  // predictor state
  cell_t      mask_cells [CELL_COUNT];
  logic       used_mark [CELL_COUNT];
  int         scan_c, scan_r;
  logic [4:0] width_reg = 5'd16, height_reg = 5'd16;

  mask_item_t pending_items[$];
  rect_t      expected_rects[$];
  int err_count = 0;
  int n_writes = 0, n_fetches = 0, n_rects = 0, n_empty = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_item(mask_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic int clamp_dim(logic [4:0] v);
    if (v == 0) return 1;
    if (v > MASK_DIM) return MASK_DIM;
    return v;
  endfunction

  function automatic bit can_merge(int c, int r, cell_t b);
    cell_t x;
    x = mask_cells[r * MASK_DIM + c];
    return !used_mark[r * MASK_DIM + c] && x.filled && x == b;
  endfunction

  task automatic apply_item(mask_item_t it);
    int w, h, c, r, rw, rh;
    bit found, grow;
    cell_t b;
    rect_t res;
    if (it.mode == MODE_WRITE) begin
      mask_cells[it.row * MASK_DIM + it.col] =
        '{it.filled, it.layer, it.ao0, it.ao1, it.ao2, it.ao3};
      used_mark[it.row * MASK_DIM + it.col] = 1'b0;
      scan_c = 0;
      scan_r = 0;
      n_writes++;
      return;
    end
    n_fetches++;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    c = scan_c;
    r = scan_r;
    found = 0;
    while (r < h && !found) begin
      if (c >= w) begin
        r++;
        c = 0;
      end else if (!used_mark[r * MASK_DIM + c] && mask_cells[r * MASK_DIM + c].filled) begin
        found = 1;
      end else begin
        c++;
      end
    end
    res = '{default: '0};
    if (!found) begin
      scan_r = h;
      scan_c = 0;
      n_empty++;
    end else begin
      b = mask_cells[r * MASK_DIM + c];
      rw = 1;
      while (c + rw < w && can_merge(c + rw, r, b)) rw++;
      rh = 1;
      grow = 1;
      while (r + rh < h && grow) begin
        for (int du = 0; du < rw; du++)
          if (!can_merge(c + du, r + rh, b)) grow = 0;
        if (grow) rh++;
      end
      for (int dv = 0; dv < rh; dv++)
        for (int du = 0; du < rw; du++)
          used_mark[(r + dv) * MASK_DIM + c + du] = 1'b1;
      scan_c = c;
      scan_r = r;
      res = '{1'b1, c[3:0], r[3:0], rw[4:0], rh[4:0], b.layer, b.ao0, b.ao1, b.ao2, b.ao3};
      n_rects++;
    end
    expected_rects.insert(expected_rects.size(), res);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("t=%0t rect %s: got %0d expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // driver: bursts with random gaps
  logic in_taken = 1'b0;
  int burst_left = 4, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        mask_item_t it;
        it = pending_items.pop_front();
        mode <= it.mode;
        cell_col <= it.col;
        cell_row <= it.row;
        cell_filled <= it.filled;
        cell_layer <= it.layer;
        cell_ao0 <= it.ao0;
        cell_ao1 <= it.ao1;
        cell_ao2 <= it.ao2;
        cell_ao3 <= it.ao3;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern: phases of full rate, coin flip and heavy stall
  int stall_phase = 0, stall_cnt = 0;
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_phase <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(20, 120);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_phase)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready)
      apply_item('{mode, cell_col, cell_row, cell_filled, cell_layer,
                   cell_ao0, cell_ao1, cell_ao2, cell_ao3});
    if (!rst && out_valid && out_ready) begin
      if (expected_rects.size() == 0) begin
        report_mismatch("unexpected", rect_valid, 0);
      end else begin
        rect_t e;
        e = expected_rects.pop_front();
        if (rect_valid !== e.valid) report_mismatch("valid", rect_valid, e.valid);
        if (rect_col !== e.col) report_mismatch("col", rect_col, e.col);
        if (rect_row !== e.row) report_mismatch("row", rect_row, e.row);
        if (rect_width !== e.width) report_mismatch("width", rect_width, e.width);
        if (rect_height !== e.height) report_mismatch("height", rect_height, e.height);
        if (rect_layer !== e.layer) report_mismatch("layer", rect_layer, e.layer);
        if (rect_ao0 !== e.ao0) report_mismatch("ao0", rect_ao0, e.ao0);
        if (rect_ao1 !== e.ao1) report_mismatch("ao1", rect_ao1, e.ao1);
        if (rect_ao2 !== e.ao2) report_mismatch("ao2", rect_ao2, e.ao2);
        if (rect_ao3 !== e.ao3) report_mismatch("ao3", rect_ao3, e.ao3);
      end
    end
  end

  function automatic mask_item_t load_item(int c, int r, cell_t v);
    return '{MODE_WRITE, c[3:0], r[3:0], v.filled, v.layer, v.ao0, v.ao1, v.ao2, v.ao3};
  endfunction

  function automatic mask_item_t fetch_item();
    mask_item_t it;
    it = '{default: '0};
    it.mode = MODE_FETCH;
    it.col = 4'($urandom);
    it.row = 4'($urandom);
    it.layer = 16'($urandom);
    return it;
  endfunction

  // hold until the block is idle: nothing queued, in flight or expected
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_rects.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  cell_t palette [4];
  int total_items = 0;

  initial begin
    cell_t v, flat;
    int c0, r0, cw, rh, k;
    logic [4:0] settings_w [6];
    logic [4:0] settings_h [6];
    settings_w = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd16};
    settings_h = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd5, 5'd16};
    for (int i = 0; i < CELL_COUNT; i++) begin
      mask_cells[i] = '0;
      used_mark[i] = 1'b0;
    end
    scan_c = 0;
    scan_r = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    write_reg(CFG_WIDTH, 5'd16);
    write_reg(CFG_HEIGHT, 5'd16);

    // load every cell once so no fetch ever reads an unwritten cell
    flat = '{1'b1, 16'h0000, 2'd0, 2'd0, 2'd0, 2'd0};
    for (int r = 0; r < MASK_DIM; r++)
      for (int c = 0; c < MASK_DIM; c++)
        queue_item(load_item(c, r, flat));
    // full uniform mask merges into one rectangle, then exhaustion twice
    for (int i = 0; i < 3; i++) queue_item(fetch_item());
    // a rewrite restarts the scan; other marks stay
    v = '{1'b1, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3};
    queue_item(load_item(15, 15, v));
    queue_item(load_item(0, 0, v));
    queue_item(load_item(1, 0, '{1'b1, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd2}));
    queue_item(load_item(2, 0, '{1'b0, 16'hFFFF, 2'd3, 2'd3, 2'd3, 2'd3}));
    queue_item(load_item(0, 1, v));
    for (int i = 0; i < 5; i++) queue_item(fetch_item());
    total_items = 256 + 13;
    drain();

    for (int ph = 0; total_items < 720; ph++) begin
      if (ph < 6) begin
        write_reg(CFG_WIDTH, settings_w[ph]);
        write_reg(CFG_HEIGHT, settings_h[ph]);
      end else begin
        if ($urandom_range(0, 1)) write_reg(CFG_WIDTH, 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, 5'($urandom_range(0, 31)));
      end
      for (int i = 0; i < 4; i++)
        palette[i] = '{1'b1, 16'($urandom), 2'($urandom), 2'($urandom),
                       2'($urandom), 2'($urandom)};
      // mostly filled blocks of equal cells, then loose cells, some blank
      k = $urandom_range(1, 4);
      for (int b = 0; b < k; b++) begin
        c0 = $urandom_range(0, 15);
        r0 = $urandom_range(0, 15);
        cw = $urandom_range(1, 6);
        rh = $urandom_range(1, 6);
        v = palette[$urandom_range(0, 3)];
        for (int r = r0; r < r0 + rh && r < MASK_DIM; r++)
          for (int c = c0; c < c0 + cw && c < MASK_DIM; c++) begin
            queue_item(load_item(c, r, v));
            total_items++;
          end
      end
      k = $urandom_range(0, 8);
      for (int i = 0; i < k; i++) begin
        v = palette[$urandom_range(0, 3)];
        if ($urandom_range(0, 3) == 0) v.filled = 1'b0;
        if ($urandom_range(0, 7) == 0) v = '{1'b1, 16'($urandom), 2'($urandom),
                                           2'($urandom), 2'($urandom), 2'($urandom)};
        queue_item(load_item($urandom_range(0, 15), $urandom_range(0, 15), v));
        total_items++;
      end
      k = $urandom_range(4, 30);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 12) == 0) begin
          queue_item(load_item($urandom_range(0, 15), $urandom_range(0, 15),
                               palette[$urandom_range(0, 3)]));
          total_items++;
        end
        queue_item(fetch_item());
        total_items++;
      end
      drain();
    end

    write_reg(CFG_WIDTH, 5'd16);
    write_reg(CFG_HEIGHT, 5'd16);
    for (int i = 0; i < 20; i++) queue_item(fetch_item());
    total_items += 20;
    drain();

    $display("covered %0d cell loads and %0d fetches: %0d rectangles, %0d exhausted",
             n_writes, n_fetches, n_rects, n_empty);
    if (err_count == 0 && expected_rects.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
